FILE: design/ritoa_pkg.sv
`timescale 1ns / 1ps

package ritoa_pkg;

  localparam int VALUE_WIDTH_DEF = 16;
  localparam int QUEUE_DEPTH_DEF = 2;

  // restoring divider: quotient bits resolved per clock
  localparam int DIV_STEPS = 8;

  localparam int RADIX_W = 6;
  localparam int CHAR_W  = 7;

  localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
  localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;

  localparam logic [RADIX_W-1:0] DIGIT_NINE = 6'd9;
  localparam logic [RADIX_W-1:0] DIGIT_TEN  = 6'd10;

  localparam logic [CHAR_W-1:0] CH_ZERO    = 7'd48;
  localparam logic [CHAR_W-1:0] CH_LOWER_A = 7'd97;

  function automatic logic [CHAR_W-1:0] digit_char(input logic [RADIX_W-1:0] d);
    logic [CHAR_W-1:0] c;
    if (d > DIGIT_NINE) begin
      c = CH_LOWER_A + CHAR_W'(d - DIGIT_TEN);
    end else begin
      c = CH_ZERO + CHAR_W'(d);
    end
    return c;
  endfunction

endpackage

FILE: design/radix_integer_to_ascii_top.sv
`timescale 1ns / 1ps

// Unsigned integer to ASCII text, radix 2 to 36.
//
// Input channel: a request (value) is taken on a clock edge with push high
// and full low. A small queue sits behind the input, so requests are taken
// while the converter is still busy or a character waits to be popped.
// Config: cfg_write loads cfg_data as the radix, clamped to 2..36 (reset 10).
// Write it only while the block has nothing in flight.
// Output channel: while empty is low, character/last hold the oldest digit,
// most significant first; pop with empty low takes it. last marks the final
// (least significant) digit. Zero converts to a single '0'.
// A request passes through the queue, then one division per digit in the
// shared restoring divider, which resolves 8 quotient bits per clock; then
// the first digit is loaded into the output register and the digits are
// read out. If the receiver stalls, the output register holds and digit
// readout waits; the queue keeps taking requests until full.
// Reset (rst, synchronous) empties the queue, idles the sequencer and
// restores the radix to 10.

module radix_integer_to_ascii_top #(
  parameter int VALUE_WIDTH = ritoa_pkg::VALUE_WIDTH_DEF,
  parameter int QUEUE_DEPTH = ritoa_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  output logic                          full,
  input  logic [VALUE_WIDTH-1:0]        value,
  input  logic                          cfg_write,
  input  logic [ritoa_pkg::RADIX_W-1:0] cfg_data,
  output logic                          empty,
  input  logic                          pop,
  output logic [ritoa_pkg::CHAR_W-1:0]  character,
  output logic                          last
);

  // queue entry: {zero flag, radix, value}
  localparam int ITEM_W = VALUE_WIDTH + ritoa_pkg::RADIX_W + 1;

  logic                          q_wr;
  logic [ITEM_W-1:0]             q_wr_data;
  logic                          q_full;
  logic                          q_rd;
  logic [ITEM_W-1:0]             q_rd_data;
  logic                          q_empty;

  logic                          div_start;
  logic [VALUE_WIDTH-1:0]        div_dividend;
  logic [ritoa_pkg::RADIX_W-1:0] div_divisor;
  logic                          div_done;
  logic [VALUE_WIDTH-1:0]        div_quotient;
  logic [ritoa_pkg::RADIX_W-1:0] div_remainder;

  // front: radix register, zero detect, enqueue
  ritoa_front #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .value     (value),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .q_wr      (q_wr),
    .q_data    (q_wr_data),
    .q_full    (q_full)
  );

  ritoa_queue #(
    .WIDTH (ITEM_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (q_wr),
    .wr_data (q_wr_data),
    .full    (q_full),
    .rd_en   (q_rd),
    .rd_data (q_rd_data),
    .empty   (q_empty)
  );

  // digit extraction: one remainder per division
  ritoa_divider #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_divider (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .done      (div_done),
    .quotient  (div_quotient),
    .remainder (div_remainder)
  );

  // back: sequencer, digit store, reversed readout into output register
  ritoa_back #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .q_empty       (q_empty),
    .q_rd          (q_rd),
    .q_data        (q_rd_data),
    .div_start     (div_start),
    .div_dividend  (div_dividend),
    .div_divisor   (div_divisor),
    .div_done      (div_done),
    .div_quotient  (div_quotient),
    .div_remainder (div_remainder),
    .pop           (pop),
    .empty         (empty),
    .character     (character),
    .last          (last)
  );

endmodule

FILE: design/ritoa_queue.sv
`timescale 1ns / 1ps

module ritoa_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = ritoa_pkg::QUEUE_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign rd_data = mem[rd_ptr];

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] n;
    if (p == PTR_W'(DEPTH - 1)) begin
      n = '0;
    end else begin
      n = p + 1'b1;
    end
    return n;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (rd_en) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (wr_en && !rd_en) begin
        count <= count + 1'b1;
      end else if (rd_en && !wr_en) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= wr_data;
    end
  end

endmodule

FILE: design/ritoa_front.sv
`timescale 1ns / 1ps

module ritoa_front #(
  parameter int VALUE_WIDTH = ritoa_pkg::VALUE_WIDTH_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    push,
  output logic                                    full,
  input  logic [VALUE_WIDTH-1:0]                  value,
  input  logic                                    cfg_write,
  input  logic [ritoa_pkg::RADIX_W-1:0]           cfg_data,
  output logic                                    q_wr,
  output logic [VALUE_WIDTH+ritoa_pkg::RADIX_W:0] q_data,
  input  logic                                    q_full
);

  logic [ritoa_pkg::RADIX_W-1:0] radix;
  logic [ritoa_pkg::RADIX_W-1:0] radix_next;
  logic                          is_zero;

  // clamp on write so the back end never sees a bad base
  always_comb begin
    radix_next = cfg_data;
    if (cfg_data < ritoa_pkg::RADIX_MIN) begin
      radix_next = ritoa_pkg::RADIX_MIN;
    end else if (cfg_data > ritoa_pkg::RADIX_MAX) begin
      radix_next = ritoa_pkg::RADIX_MAX;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      radix <= ritoa_pkg::RADIX_RESET;
    end else if (cfg_write) begin
      radix <= radix_next;
    end
  end

  // zero skips the divider entirely
  assign is_zero = (value == '0);
  assign full    = q_full;
  assign q_wr    = push && !q_full;
  assign q_data  = {is_zero, radix, value};

endmodule

FILE: design/ritoa_divider.sv
`timescale 1ns / 1ps

module ritoa_divider #(
  parameter int VALUE_WIDTH = ritoa_pkg::VALUE_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [VALUE_WIDTH-1:0]        dividend,
  input  logic [ritoa_pkg::RADIX_W-1:0] divisor,
  output logic                          done,
  output logic [VALUE_WIDTH-1:0]        quotient,
  output logic [ritoa_pkg::RADIX_W-1:0] remainder
);

  localparam int STEPS = ritoa_pkg::DIV_STEPS;
  localparam int RW    = ritoa_pkg::RADIX_W;
  localparam int CYC   = (VALUE_WIDTH + STEPS - 1) / STEPS;
  localparam int DIV_W = CYC * STEPS;
  localparam int CNT_W = $clog2(CYC + 1);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [DIV_W-1:0] dvd;
  logic [RW-1:0]    rem;
  logic [RW-1:0]    dsr;
  logic [DIV_W-1:0] dvd_next;
  logic [RW-1:0]    rem_next;

  // STEPS restoring steps per clock; quotient bits shift in at the bottom
  always_comb begin
    logic [RW:0] t;
    dvd_next = dvd;
    rem_next = rem;
    for (int i = 0; i < STEPS; i++) begin
      t        = {rem_next, dvd_next[DIV_W-1]};
      dvd_next = {dvd_next[DIV_W-2:0], 1'b0};
      if (t >= {1'b0, dsr}) begin
        t           = t - {1'b0, dsr};
        dvd_next[0] = 1'b1;
      end
      rem_next = t[RW-1:0];
    end
  end

  assign done      = busy && (cnt == CNT_W'(1));
  assign quotient  = dvd_next[VALUE_WIDTH-1:0];
  assign remainder = rem_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CNT_W'(CYC);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= DIV_W'(dividend);
      rem <= '0;
      dsr <= divisor;
    end else if (busy) begin
      dvd <= dvd_next;
      rem <= rem_next;
    end
  end

endmodule

FILE: design/ritoa_back.sv
`timescale 1ns / 1ps

module ritoa_back #(
  parameter int VALUE_WIDTH = ritoa_pkg::VALUE_WIDTH_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    q_empty,
  output logic                                    q_rd,
  input  logic [VALUE_WIDTH+ritoa_pkg::RADIX_W:0] q_data,
  output logic                                    div_start,
  output logic [VALUE_WIDTH-1:0]                  div_dividend,
  output logic [ritoa_pkg::RADIX_W-1:0]           div_divisor,
  input  logic                                    div_done,
  input  logic [VALUE_WIDTH-1:0]                  div_quotient,
  input  logic [ritoa_pkg::RADIX_W-1:0]           div_remainder,
  input  logic                                    pop,
  output logic                                    empty,
  output logic [ritoa_pkg::CHAR_W-1:0]            character,
  output logic                                    last
);

  localparam int RW    = ritoa_pkg::RADIX_W;
  localparam int IDX_W = $clog2(VALUE_WIDTH);
  localparam int CNT_W = $clog2(VALUE_WIDTH + 1);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_DIV  = 3'b010,
    S_EMIT = 3'b100
  } back_state_t;

  back_state_t state;
  back_state_t state_next;

  logic [RW-1:0]          digit_store [VALUE_WIDTH];
  logic [CNT_W-1:0]       digit_count;
  logic [IDX_W-1:0]       rd_idx;
  logic [RW-1:0]          cur_radix;
  logic                   out_valid;

  logic [VALUE_WIDTH-1:0] item_value;
  logic [RW-1:0]          item_radix;
  logic                   item_zero;

  logic                   st_we;
  logic [IDX_W-1:0]       st_addr;
  logic [RW-1:0]          st_data;
  logic                   load_out;

  assign item_value = q_data[VALUE_WIDTH-1:0];
  assign item_radix = q_data[VALUE_WIDTH+RW-1:VALUE_WIDTH];
  assign item_zero  = q_data[VALUE_WIDTH+RW];

  always_comb begin
    state_next   = state;
    q_rd         = 1'b0;
    div_start    = 1'b0;
    div_dividend = item_value;
    div_divisor  = item_radix;
    st_we        = 1'b0;
    st_addr      = digit_count[IDX_W-1:0];
    st_data      = div_remainder;
    load_out     = 1'b0;
    case (state)
      S_IDLE: begin
        if (!q_empty) begin
          q_rd = 1'b1;
          if (item_zero) begin
            st_we      = 1'b1;
            st_addr    = '0;
            st_data    = '0;
            state_next = S_EMIT;
          end else begin
            div_start  = 1'b1;
            state_next = S_DIV;
          end
        end
      end
      S_DIV: begin
        div_dividend = div_quotient;
        div_divisor  = cur_radix;
        if (div_done) begin
          st_we = 1'b1;
          if (div_quotient == '0) begin
            state_next = S_EMIT;
          end else begin
            div_start = 1'b1;
          end
        end
      end
      S_EMIT: begin
        load_out = !out_valid || pop;
        if (load_out && (rd_idx == '0)) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      digit_count <= '0;
      rd_idx      <= '0;
      out_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_IDLE && !q_empty) begin
        digit_count <= '0;
        rd_idx      <= '0;
      end else if (state == S_DIV && div_done) begin
        digit_count <= digit_count + 1'b1;
        rd_idx      <= digit_count[IDX_W-1:0];
      end else if (load_out && (rd_idx != '0)) begin
        rd_idx <= rd_idx - 1'b1;
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (st_we) begin
      digit_store[st_addr] <= st_data;
    end
    if (state == S_IDLE && !q_empty) begin
      cur_radix <= item_radix;
    end
    if (load_out) begin
      character <= ritoa_pkg::digit_char(digit_store[rd_idx]);
      last      <= (rd_idx == '0);
    end
  end

  assign empty = !out_valid;

endmodule

FILE: verif/radix_integer_to_ascii_top_tb.sv
`timescale 1ns / 1ps

module radix_integer_to_ascii_top_tb;

  localparam int VALUE_W = ritoa_pkg::VALUE_WIDTH_DEF;
  localparam int RADIX_W = ritoa_pkg::RADIX_W;
  localparam int CHAR_W  = ritoa_pkg::CHAR_W;
  // Cycles with no handshake on either side before the run is declared hung.
  // Slowest gap: a 16-digit radix-2 conversion behind a receiver
  // at a 5% pop rate, plus long sender gaps; this is several times that.
  localparam int IDLE_LIMIT = 5000;
  // Drain time after the last expected character: well over one conversion.
  localparam int DRAIN_CYCLES = 80;
  localparam int RANDOM_PHASES = 15;
  localparam int ITEMS_PER_PHASE = 30;
  localparam int DIR_ROWS = 28;

  // One expected character on the output side.
  typedef struct {
    logic [CHAR_W-1:0] ch;
    logic              is_last;
  } char_exp_t;

  // Directed row: either a radix write or a value request. An empty text
  // means the expected digits come from the predictor.
  typedef struct {
    bit                 is_cfg;
    logic [RADIX_W-1:0] radix_wr;
    logic [VALUE_W-1:0] val;
    string              text;
  } dir_row_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               push = 1'b0;
  logic [VALUE_W-1:0] value = '0;
  logic               cfg_write = 1'b0;
  logic [RADIX_W-1:0] cfg_data = '0;
  logic               pop = 1'b0;
  logic               full;
  logic               empty;
  logic [CHAR_W-1:0]  character;
  logic               last;

  char_exp_t          pending_chars[$];
  char_exp_t          want;
  logic [RADIX_W-1:0] radix_model = ritoa_pkg::RADIX_RESET;
  int                 mismatch_count = 0;
  int                 idle_cycles = 0;
  int                 pop_pct = 100;
  int                 pop_window = 0;

  dir_row_t dir_rows [DIR_ROWS] = '{
    // radix 10 straight out of reset
    '{1'b0, 6'd0,  16'd0,      "0"},
    '{1'b0, 6'd0,  16'd65535,  "65535"},
    '{1'b0, 6'd0,  16'd9,      "9"},
    '{1'b0, 6'd0,  16'd10,     "10"},
    '{1'b0, 6'd0,  16'd12345,  "12345"},
    // zero written clamps up to binary: widest output, sixteen digits
    '{1'b1, 6'd0,  16'd0,      ""},
    '{1'b0, 6'd0,  16'd65535,  "1111111111111111"},
    '{1'b0, 6'd0,  16'd0,      "0"},
    '{1'b0, 6'd0,  16'd32768,  "1000000000000000"},
    '{1'b0, 6'd0,  16'd1,      "1"},
    // all-ones radix clamps down to 36
    '{1'b1, 6'd63, 16'd0,      ""},
    '{1'b0, 6'd0,  16'd35,     "z"},
    '{1'b0, 6'd0,  16'd36,     "10"},
    '{1'b0, 6'd0,  16'd65535,  "1ekf"},
    '{1'b1, 6'd16, 16'd0,      ""},
    '{1'b0, 6'd0,  16'habcd,   "abcd"},
    '{1'b0, 6'd0,  16'h0f0f,   "f0f"},
    // just above the top of the range
    '{1'b1, 6'd37, 16'd0,      ""},
    '{1'b0, 6'd0,  16'd1295,   "zz"},
    // just below the bottom of the range
    '{1'b1, 6'd1,  16'd0,      ""},
    '{1'b0, 6'd0,  16'd5,      "101"},
    '{1'b1, 6'd35, 16'd0,      ""},
    '{1'b0, 6'd0,  16'h5a5a,   ""},
    '{1'b1, 6'd2,  16'd0,      ""},
    '{1'b0, 6'd0,  16'haaaa,   ""},
    '{1'b1, 6'd36, 16'd0,      ""},
    '{1'b0, 6'd0,  16'd46655,  "zzz"},
    '{1'b0, 6'd0,  16'h5555,   ""}
  };

  radix_integer_to_ascii_top dut (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .value     (value),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .empty     (empty),
    .pop       (pop),
    .character (character),
    .last      (last)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $realtime, msg);
    mismatch_count++;
  endtask

  function automatic logic [CHAR_W-1:0] ascii_of(input logic [RADIX_W-1:0] d);
    if (d >= 6'd10) begin
      return 7'(d - 6'd10) + 7'h61;  // 'a'
    end
    return 7'(d) + 7'h30;            // '0'
  endfunction

  // Predictor: repeated division by the current radix, remainders collected
  // least significant first, queued most significant first.
  function automatic void queue_digits_of(input logic [VALUE_W-1:0] v);
    logic [RADIX_W-1:0] rems [VALUE_W];
    logic [VALUE_W-1:0] q;
    int                 n;
    char_exp_t          ent;
    q = v;
    n = 0;
    if (q == '0) begin
      rems[0] = '0;
      n = 1;
    end
    while (q != '0 && n < VALUE_W) begin
      rems[n] = RADIX_W'(q % VALUE_W'(radix_model));
      q = q / VALUE_W'(radix_model);
      n++;
    end
    for (int k = n - 1; k >= 0; k--) begin
      ent.ch = ascii_of(rems[k]);
      ent.is_last = (k == 0);
      pending_chars.push_back(ent);
    end
  endfunction

  // Typed-in expectation from a directed row.
  function automatic void queue_text(input string text);
    byte       b;
    char_exp_t ent;
    for (int i = 0; i < text.len(); i++) begin
      b = text[i];
      ent.ch = b[CHAR_W-1:0];
      ent.is_last = (i == text.len() - 1);
      pending_chars.push_back(ent);
    end
  endfunction

  // Drives one request and returns at the edge that takes it; push is left
  // high so the next request can follow without a gap.
  task automatic send_value(input logic [VALUE_W-1:0] v, input string text);
    push <= 1'b1;
    value <= v;
    do @(posedge clk); while (full);
    if (text.len() != 0) begin
      queue_text(text);
    end else begin
      queue_digits_of(v);
    end
  endtask

  // Radix write: only once every expected character has been popped. Every
  // request yields at least one character, so the last pop means idle.
  task automatic write_radix(input logic [RADIX_W-1:0] d);
    push <= 1'b0;
    while (pending_chars.size() != 0) @(posedge clk);
    cfg_write <= 1'b1;
    cfg_data <= d;
    @(posedge clk);
    cfg_write <= 1'b0;
    cfg_data <= RADIX_W'($urandom_range(0, 63));
    if (d < ritoa_pkg::RADIX_MIN) begin
      radix_model = ritoa_pkg::RADIX_MIN;
    end else if (d > ritoa_pkg::RADIX_MAX) begin
      radix_model = ritoa_pkg::RADIX_MAX;
    end else begin
      radix_model = d;
    end
  endtask

  // Random request value, biased toward digit-count boundaries of the radix.
  function automatic logic [VALUE_W-1:0] pick_value();
    int sel;
    int p;
    int steps;
    sel = $urandom_range(0, 9);
    if (sel < 5) begin
      return VALUE_W'($urandom_range(0, 65535));
    end else if (sel == 5) begin
      return '0;
    end else if (sel == 6) begin
      return '1;
    end else if (sel == 7) begin
      return VALUE_W'($urandom_range(0, 2 * int'(radix_model)));
    end
    // radix^k, or one either side of it
    p = 1;
    steps = $urandom_range(1, 16);
    repeat (steps) begin
      if (p * int'(radix_model) <= 65535) begin
        p = p * int'(radix_model);
      end
    end
    p = p + $urandom_range(0, 2) - 1;
    if (p > 65535) begin
      p = 65535;
    end
    return VALUE_W'(p);
  endfunction

  // Output side: check each popped character against the oldest expectation,
  // then choose the next pop. The pop rate changes in windows of random
  // length, from full rate down to long stalls.
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (pending_chars.size() == 0) begin
          report_mismatch($sformatf("unexpected character 0x%02h last=%0b", character, last));
        end else begin
          want = pending_chars.pop_front();
          if (character !== want.ch) begin
            report_mismatch($sformatf("character 0x%02h, expected 0x%02h",
                                      character, want.ch));
          end
          if (last !== want.is_last) begin
            report_mismatch($sformatf("last %0b, expected %0b on character 0x%02h",
                                      last, want.is_last, want.ch));
          end
        end
      end
      if (pop_window == 0) begin
        case ($urandom_range(0, 4))
          0, 1: pop_pct = 100;
          2: pop_pct = 60;
          3: pop_pct = 25;
          default: pop_pct = 5;
        endcase
        pop_window = $urandom_range(10, 80);
      end else begin
        pop_window--;
      end
      pop <= ($urandom_range(1, 100) <= pop_pct);
    end
  end

  // Watchdog: any handshake on either side restarts the count.
  always @(posedge clk) begin
    if (!rst) begin
      if ((push && !full) || (pop && !empty)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    int burst_left;
    int gap;
    logic [RADIX_W-1:0] phase_radix;

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed table: reset radix, extremes of value and radix, clamping.
    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg) begin
        write_radix(dir_rows[i].radix_wr);
      end else begin
        send_value(dir_rows[i].val, dir_rows[i].text);
      end
    end

    // Random phases: one radix per phase, the first few at the clamp edges.
    burst_left = $urandom_range(1, 12);
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      case (ph)
        0: phase_radix = ritoa_pkg::RADIX_MIN;
        1: phase_radix = ritoa_pkg::RADIX_MAX;
        2: phase_radix = '0;
        3: phase_radix = '1;
        4: phase_radix = ritoa_pkg::RADIX_MIN - 1'b1;
        5: phase_radix = ritoa_pkg::RADIX_MAX + 1'b1;
        default: phase_radix = RADIX_W'($urandom_range(0, 63));
      endcase
      write_radix(phase_radix);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        send_value(pick_value(), "");
        burst_left--;
        if (burst_left == 0) begin
          // drop push for a gap so it is never dropped and raised
          // in the same step
          push <= 1'b0;
          gap = ($urandom_range(0, 5) == 0) ? $urandom_range(15, 40) : $urandom_range(1, 6);
          repeat (gap) @(posedge clk);
          burst_left = $urandom_range(1, 12);
        end
      end
    end

    push <= 1'b0;
    while (pending_chars.size() != 0) @(posedge clk);
    // stray characters after the last expected one show up as unexpected
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
